[rtl/circle_transformed_bounding_box_assert.svh]
// assertion macros for the circle bounding box block
`ifndef CIRCLE_TRANSFORMED_BOUNDING_BOX_ASSERT_SVH
`define CIRCLE_TRANSFORMED_BOUNDING_BOX_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define CTBB_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CTBB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ctbb_pkg.sv]
// ----------------------------------------------------------------------------
// ctbb_pkg
// shared types and codes of the transformed circle bounding box block
// ----------------------------------------------------------------------------
package ctbb_pkg;

  // default coordinate format
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int KIND_W      = 3;
  localparam int STATUS_W    = 2;
  localparam int CFG_INDEX_W = 3;

  // transform kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_IDENTITY    = 3'd0,
    KIND_TRANSLATION = 3'd1,
    KIND_SCALING     = 3'd2,
    KIND_SWAP        = 3'd3,
    KIND_ROTATION    = 3'd4,
    KIND_AFFINE      = 3'd5,
    KIND_PROJECTION  = 3'd6,
    KIND_DEGENERATE  = 3'd7
  } kind_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_DEGENERATE = 2'd1,
    STATUS_PROJECTION = 2'd2
  } status_t;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KIND    = 3'd0,
    REG_COEF_XX = 3'd1,
    REG_COEF_XY = 3'd2,
    REG_COEF_YX = 3'd3,
    REG_COEF_YY = 3'd4,
    REG_SHIFT_X = 3'd5,
    REG_SHIFT_Y = 3'd6
  } reg_index_t;

  // control travelling with each request
  typedef struct packed {
    logic  valid;
    kind_t kind;
  } ctl_t;

endpackage

[rtl/ctbb_front.sv]
// ----------------------------------------------------------------------------
// ctbb_front
// capture, products, sums and centre mapping (four register stages)
// ----------------------------------------------------------------------------
module ctbb_front #(
  parameter int COORD_WIDTH = ctbb_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = ctbb_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  input  logic        [COORD_WIDTH-2:0] radius,
  input  ctbb_pkg::kind_t               kind,
  input  logic signed [COORD_WIDTH-1:0] coef_xx,
  input  logic signed [COORD_WIDTH-1:0] coef_xy,
  input  logic signed [COORD_WIDTH-1:0] coef_yx,
  input  logic signed [COORD_WIDTH-1:0] coef_yy,
  input  logic signed [COORD_WIDTH-1:0] shift_x,
  input  logic signed [COORD_WIDTH-1:0] shift_y,
  output ctbb_pkg::ctl_t                ctl_out,
  output logic signed [COORD_WIDTH-1:0] pos_x,
  output logic signed [COORD_WIDTH-1:0] pos_y,
  output logic signed [COORD_WIDTH-1:0] rlin_x,
  output logic signed [COORD_WIDTH-1:0] rlin_y,
  output logic        [COORD_WIDTH-2:0] rad,
  output logic      [2*COORD_WIDTH-1:0] sq_x,
  output logic      [2*COORD_WIDTH-1:0] sq_y
);
  import ctbb_pkg::*;

  localparam int W = COORD_WIDTH;
  localparam int F = FRAC_BITS;
  localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

  // clamp a wide signed value to the coordinate range
  function automatic logic signed [W-1:0] sat_w(input logic signed [2*W+1:0] v);
    logic signed [W-1:0] res;
    if (v > CMAX) begin
      res = CMAX;
    end else if (v < CMIN) begin
      res = CMIN;
    end else begin
      res = v[W-1:0];
    end
    return res;
  endfunction

  // stage 1: request capture
  ctl_t                ctl1_r, ctl1_nxt;
  logic signed [W-1:0] cx1_r, cy1_r;
  logic        [W-2:0] r1_r;

  assign ctl1_nxt = '{valid: in_valid, kind: kind};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else begin
      ctl1_r <= ctl1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx1_r <= center_x;
    cy1_r <= center_y;
    r1_r  <= radius;
  end

  // stage 2: operand select and products
  logic                  use_diag, use_cross;
  logic signed [W-1:0]   op_a, op_b, op_c, op_d, rsel_x, rsel_y, rad_s;
  logic        [W-1:0]   mag_xx, mag_xy, mag_yx, mag_yy;
  logic signed [2*W-1:0] pa_nxt, pb_nxt, pc_nxt, pd_nxt, prx_nxt, pry_nxt;
  logic        [2*W-1:0] qxx_nxt, qxy_nxt, qyx_nxt, qyy_nxt;

  ctl_t                  ctl2_r;
  logic signed [2*W-1:0] pa2_r, pb2_r, pc2_r, pd2_r, prx2_r, pry2_r;
  logic        [2*W-1:0] qxx2_r, qxy2_r, qyx2_r, qyy2_r;
  logic signed [W-1:0]   cx2_r, cy2_r;
  logic        [W-2:0]   r2_r;

  always_comb begin
    use_diag  = (ctl1_r.kind == KIND_SCALING) || (ctl1_r.kind == KIND_ROTATION) ||
                (ctl1_r.kind == KIND_AFFINE);
    use_cross = (ctl1_r.kind == KIND_SWAP) || (ctl1_r.kind == KIND_ROTATION) ||
                (ctl1_r.kind == KIND_AFFINE);
    op_a   = use_diag  ? coef_xx : '0;
    op_b   = use_cross ? coef_yx : '0;
    op_c   = use_cross ? coef_xy : '0;
    op_d   = use_diag  ? coef_yy : '0;
    rsel_x = (ctl1_r.kind == KIND_SWAP) ? coef_yx : coef_xx;
    rsel_y = (ctl1_r.kind == KIND_SWAP) ? coef_xy : coef_yy;
    rad_s  = {1'b0, r1_r};
    mag_xx = coef_xx[W-1] ? W'(-coef_xx) : W'(coef_xx);
    mag_xy = coef_xy[W-1] ? W'(-coef_xy) : W'(coef_xy);
    mag_yx = coef_yx[W-1] ? W'(-coef_yx) : W'(coef_yx);
    mag_yy = coef_yy[W-1] ? W'(-coef_yy) : W'(coef_yy);
    pa_nxt  = cx1_r * op_a;
    pb_nxt  = cy1_r * op_b;
    pc_nxt  = cx1_r * op_c;
    pd_nxt  = cy1_r * op_d;
    prx_nxt = rad_s * rsel_x;
    pry_nxt = rad_s * rsel_y;
    qxx_nxt = mag_xx * mag_xx;
    qxy_nxt = mag_xy * mag_xy;
    qyx_nxt = mag_yx * mag_yx;
    qyy_nxt = mag_yy * mag_yy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else begin
      ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    pa2_r  <= pa_nxt;
    pb2_r  <= pb_nxt;
    pc2_r  <= pc_nxt;
    pd2_r  <= pd_nxt;
    prx2_r <= prx_nxt;
    pry2_r <= pry_nxt;
    qxx2_r <= qxx_nxt;
    qxy2_r <= qxy_nxt;
    qyx2_r <= qyx_nxt;
    qyy2_r <= qyy_nxt;
    cx2_r  <= cx1_r;
    cy2_r  <= cy1_r;
    r2_r   <= r1_r;
  end

  // stage 3: sums of products, radius scaling
  logic                  pass2;
  logic signed [2*W:0]   sumx_nxt, sumy_nxt;
  logic        [2*W:0]   sqx_full, sqy_full;
  logic signed [2*W-1:0] prx_sh, pry_sh;
  logic signed [W-1:0]   rlx_nxt, rly_nxt;

  ctl_t                ctl3_r;
  logic signed [2*W:0] sumx3_r, sumy3_r;
  logic      [2*W-1:0] sqx3_r, sqy3_r;
  logic signed [W-1:0] rlx3_r, rly3_r, cx3_r, cy3_r;
  logic        [W-2:0] r3_r;

  always_comb begin
    pass2    = (ctl2_r.kind == KIND_IDENTITY) || (ctl2_r.kind == KIND_TRANSLATION);
    sumx_nxt = {pa2_r[2*W-1], pa2_r} + {pb2_r[2*W-1], pb2_r};
    sumy_nxt = {pc2_r[2*W-1], pc2_r} + {pd2_r[2*W-1], pd2_r};
    sqx_full = {1'b0, qxx2_r} + {1'b0, qyx2_r};
    sqy_full = {1'b0, qxy2_r} + {1'b0, qyy2_r};
    prx_sh   = prx2_r >>> F;
    pry_sh   = pry2_r >>> F;
    rlx_nxt  = pass2 ? {1'b0, r2_r} : sat_w({{2{prx_sh[2*W-1]}}, prx_sh});
    rly_nxt  = pass2 ? {1'b0, r2_r} : sat_w({{2{pry_sh[2*W-1]}}, pry_sh});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r <= '0;
    end else begin
      ctl3_r <= ctl2_r;
    end
  end

  always_ff @(posedge clk) begin
    sumx3_r <= sumx_nxt;
    sumy3_r <= sumy_nxt;
    sqx3_r  <= sqx_full[2*W-1:0];
    sqy3_r  <= sqy_full[2*W-1:0];
    rlx3_r  <= rlx_nxt;
    rly3_r  <= rly_nxt;
    cx3_r   <= cx2_r;
    cy3_r   <= cy2_r;
    r3_r    <= r2_r;
  end

  // stage 4: floor shift, offset and clamp of the centre
  logic                  pass3;
  logic signed [2*W:0]   shx, shy, base_x, base_y;
  logic signed [W-1:0]   off_x, off_y;
  logic signed [2*W+1:0] tot_x, tot_y;

  ctl_t                ctl4_r;
  logic signed [W-1:0] px4_r, py4_r, rlx4_r, rly4_r;
  logic      [2*W-1:0] sqx4_r, sqy4_r;
  logic        [W-2:0] r4_r;

  always_comb begin
    pass3  = (ctl3_r.kind == KIND_IDENTITY) || (ctl3_r.kind == KIND_TRANSLATION);
    shx    = sumx3_r >>> F;
    shy    = sumy3_r >>> F;
    base_x = pass3 ? {{(W+1){cx3_r[W-1]}}, cx3_r} : shx;
    base_y = pass3 ? {{(W+1){cy3_r[W-1]}}, cy3_r} : shy;
    off_x  = (ctl3_r.kind == KIND_IDENTITY) ? '0 : shift_x;
    off_y  = (ctl3_r.kind == KIND_IDENTITY) ? '0 : shift_y;
    tot_x  = {base_x[2*W], base_x} + {{(W+2){off_x[W-1]}}, off_x};
    tot_y  = {base_y[2*W], base_y} + {{(W+2){off_y[W-1]}}, off_y};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl4_r <= '0;
    end else begin
      ctl4_r <= ctl3_r;
    end
  end

  always_ff @(posedge clk) begin
    px4_r  <= sat_w(tot_x);
    py4_r  <= sat_w(tot_y);
    rlx4_r <= rlx3_r;
    rly4_r <= rly3_r;
    sqx4_r <= sqx3_r;
    sqy4_r <= sqy3_r;
    r4_r   <= r3_r;
  end

  assign ctl_out = ctl4_r;
  assign pos_x   = px4_r;
  assign pos_y   = py4_r;
  assign rlin_x  = rlx4_r;
  assign rlin_y  = rly4_r;
  assign rad     = r4_r;
  assign sq_x    = sqx4_r;
  assign sq_y    = sqy4_r;

endmodule

[rtl/ctbb_isqrt.sv]
// ----------------------------------------------------------------------------
// ctbb_isqrt
// pipelined floor square root, one root bit per register stage
// ----------------------------------------------------------------------------
module ctbb_isqrt #(
  parameter int COORD_WIDTH = ctbb_pkg::COORD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic [2*COORD_WIDTH-1:0] radicand,
  output logic   [COORD_WIDTH-1:0] root
);
  import ctbb_pkg::*;

  localparam int W = COORD_WIDTH;

  logic [W+1:0]   rem_r  [W-1];
  logic [2*W-1:0] rad_r  [W-1];
  logic [W-1:0]   root_r [W];

  // one restoring step per stage, two radicand bits consumed each
  for (genvar i = 0; i < W; i++) begin : g_step
    logic [W+1:0]   rem_in, acc, trial;
    logic [2*W-1:0] rad_in;
    logic [W-1:0]   root_in;
    logic           ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign rad_in  = radicand;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign rad_in  = rad_r[i-1];
      assign root_in = root_r[i-1];
    end

    assign acc   = {rem_in[W-1:0], rad_in[2*W-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = (acc >= trial);

    always_ff @(posedge clk) begin
      root_r[i] <= {root_in[W-2:0], ge};
    end

    if (i < W-1) begin : g_fwd
      always_ff @(posedge clk) begin
        rem_r[i] <= ge ? (acc - trial) : acc;
        rad_r[i] <= rad_in << 2;
      end
    end
  end

  assign root = root_r[W-1];

endmodule

[rtl/ctbb_back.sv]
// ----------------------------------------------------------------------------
// ctbb_back
// half extents, radius select and ordered box edges (three register stages)
// ----------------------------------------------------------------------------
module ctbb_back #(
  parameter int COORD_WIDTH = ctbb_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = ctbb_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ctbb_pkg::ctl_t                ctl_in,
  input  logic signed [COORD_WIDTH-1:0] pos_x,
  input  logic signed [COORD_WIDTH-1:0] pos_y,
  input  logic signed [COORD_WIDTH-1:0] rlin_x,
  input  logic signed [COORD_WIDTH-1:0] rlin_y,
  input  logic        [COORD_WIDTH-2:0] rad,
  input  logic        [COORD_WIDTH-1:0] root_x,
  input  logic        [COORD_WIDTH-1:0] root_y,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] box_left,
  output logic signed [COORD_WIDTH-1:0] box_top,
  output logic signed [COORD_WIDTH-1:0] box_right,
  output logic signed [COORD_WIDTH-1:0] box_bottom,
  output ctbb_pkg::status_t             status
);
  import ctbb_pkg::*;

  localparam int W = COORD_WIDTH;
  localparam int F = FRAC_BITS;
  localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

  // clamp a one-bit-grown sum to the coordinate range
  function automatic logic signed [W-1:0] sat_1(input logic [W:0] v);
    logic signed [W-1:0] res;
    if (v[W] != v[W-1]) begin
      res = v[W] ? CMIN : CMAX;
    end else begin
      res = v[W-1:0];
    end
    return res;
  endfunction

  // stage 1: radius times root
  ctl_t                ctl1_r;
  logic      [2*W-2:0] ex1_r, ey1_r;
  logic signed [W-1:0] px1_r, py1_r, rlx1_r, rly1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else begin
      ctl1_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    ex1_r  <= rad * root_x;
    ey1_r  <= rad * root_y;
    px1_r  <= pos_x;
    py1_r  <= pos_y;
    rlx1_r <= rlin_x;
    rly1_r <= rlin_y;
  end

  // stage 2: scale down, clamp and pick the per-axis radius
  logic      [2*W-2:0] exs, eys;
  logic signed [W-1:0] extx, exty, rx_nxt, ry_nxt;
  logic                use_ext;

  ctl_t                ctl2_r;
  logic signed [W-1:0] px2_r, py2_r, rx2_r, ry2_r;

  always_comb begin
    exs     = ex1_r >> F;
    eys     = ey1_r >> F;
    extx    = (|exs[2*W-2:W-1]) ? CMAX : {1'b0, exs[W-2:0]};
    exty    = (|eys[2*W-2:W-1]) ? CMAX : {1'b0, eys[W-2:0]};
    use_ext = (ctl1_r.kind == KIND_ROTATION) || (ctl1_r.kind == KIND_AFFINE);
    rx_nxt  = use_ext ? extx : rlx1_r;
    ry_nxt  = use_ext ? exty : rly1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else begin
      ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    px2_r <= px1_r;
    py2_r <= py1_r;
    rx2_r <= rx_nxt;
    ry2_r <= ry_nxt;
  end

  // stage 3: edges, ordering and status
  logic signed [W-1:0] x0, x1, y0, y1;
  logic signed [W-1:0] left_nxt, right_nxt, top_nxt, bottom_nxt;
  status_t             status_nxt;

  logic                valid_r;
  logic signed [W-1:0] left_r, right_r, top_r, bottom_r;
  status_t             status_r;

  always_comb begin
    x0 = sat_1({px2_r[W-1], px2_r} - {rx2_r[W-1], rx2_r});
    x1 = sat_1({px2_r[W-1], px2_r} + {rx2_r[W-1], rx2_r});
    y0 = sat_1({py2_r[W-1], py2_r} - {ry2_r[W-1], ry2_r});
    y1 = sat_1({py2_r[W-1], py2_r} + {ry2_r[W-1], ry2_r});
    case (ctl2_r.kind)
      KIND_DEGENERATE: status_nxt = STATUS_DEGENERATE;
      KIND_PROJECTION: status_nxt = STATUS_PROJECTION;
      default:         status_nxt = STATUS_OK;
    endcase
    if (status_nxt != STATUS_OK) begin
      left_nxt   = '0;
      right_nxt  = '0;
      top_nxt    = '0;
      bottom_nxt = '0;
    end else begin
      left_nxt   = (x0 > x1) ? x1 : x0;
      right_nxt  = (x0 > x1) ? x0 : x1;
      top_nxt    = (y0 > y1) ? y1 : y0;
      bottom_nxt = (y0 > y1) ? y0 : y1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl2_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    left_r   <= left_nxt;
    right_r  <= right_nxt;
    top_r    <= top_nxt;
    bottom_r <= bottom_nxt;
    status_r <= status_nxt;
  end

  assign out_valid  = valid_r;
  assign box_left   = left_r;
  assign box_top    = top_r;
  assign box_right  = right_r;
  assign box_bottom = bottom_r;
  assign status     = status_r;

endmodule

[rtl/circle_transformed_bounding_box.sv]
// ----------------------------------------------------------------------------
// circle_transformed_bounding_box
// axis-aligned box of a circle after a configured 2D transform
// ----------------------------------------------------------------------------
// A request (centre, radius) is taken whenever start is high and busy is low;
// one request can be taken every clock cycle. Its box appears on the out_
// ports, marked by out_valid for a single cycle, after passing the front
// stages, the half-extent square root, which produces one root bit per
// pipeline stage, and the back stages. Results cannot be held off, so
// the receiver must take every strobe. busy is high only during reset and
// the first cycle after it. Configuration writes are always taken and must
// only be made while no request is in flight.
module circle_transformed_bounding_box #(
  parameter int COORD_WIDTH = ctbb_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = ctbb_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COORD_WIDTH-1:0]       in_center_x,
  input  logic signed [COORD_WIDTH-1:0]       in_center_y,
  input  logic        [COORD_WIDTH-2:0]       in_radius,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ctbb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [COORD_WIDTH-1:0]              cfg_data,
  output logic                                out_valid,
  output logic signed [COORD_WIDTH-1:0]       out_box_left,
  output logic signed [COORD_WIDTH-1:0]       out_box_top,
  output logic signed [COORD_WIDTH-1:0]       out_box_right,
  output logic signed [COORD_WIDTH-1:0]       out_box_bottom,
  output logic [ctbb_pkg::STATUS_W-1:0]       out_status
);
  import ctbb_pkg::*;

  localparam int W = COORD_WIDTH;
  localparam logic signed [W-1:0] ONE = W'(1) << FRAC_BITS;

  // configuration registers
  kind_t               kind_r;
  logic signed [W-1:0] coef_xx_r, coef_xy_r, coef_yx_r, coef_yy_r;
  logic signed [W-1:0] shift_x_r, shift_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r    <= KIND_IDENTITY;
      coef_xx_r <= ONE;
      coef_xy_r <= '0;
      coef_yx_r <= '0;
      coef_yy_r <= ONE;
      shift_x_r <= '0;
      shift_y_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KIND:    kind_r    <= kind_t'(cfg_data[KIND_W-1:0]);
        REG_COEF_XX: coef_xx_r <= cfg_data;
        REG_COEF_XY: coef_xy_r <= cfg_data;
        REG_COEF_YX: coef_yx_r <= cfg_data;
        REG_COEF_YY: coef_yy_r <= cfg_data;
        REG_SHIFT_X: shift_x_r <= cfg_data;
        REG_SHIFT_Y: shift_y_r <= cfg_data;
        default:     ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // request acceptance
  logic busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  // front stages
  ctl_t                f_ctl;
  logic signed [W-1:0] f_px, f_py, f_rlx, f_rly;
  logic        [W-2:0] f_rad;
  logic      [2*W-1:0] f_sqx, f_sqy;

  ctbb_front #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(start && !busy_r),
    .center_x(in_center_x),
    .center_y(in_center_y),
    .radius  (in_radius),
    .kind    (kind_r),
    .coef_xx (coef_xx_r),
    .coef_xy (coef_xy_r),
    .coef_yx (coef_yx_r),
    .coef_yy (coef_yy_r),
    .shift_x (shift_x_r),
    .shift_y (shift_y_r),
    .ctl_out (f_ctl),
    .pos_x   (f_px),
    .pos_y   (f_py),
    .rlin_x  (f_rlx),
    .rlin_y  (f_rly),
    .rad     (f_rad),
    .sq_x    (f_sqx),
    .sq_y    (f_sqy)
  );

  // square roots of the column norms
  logic [W-1:0] root_x, root_y;

  ctbb_isqrt #(.COORD_WIDTH(COORD_WIDTH)) u_sqrt_x (
    .clk     (clk),
    .radicand(f_sqx),
    .root    (root_x)
  );

  ctbb_isqrt #(.COORD_WIDTH(COORD_WIDTH)) u_sqrt_y (
    .clk     (clk),
    .radicand(f_sqy),
    .root    (root_y)
  );

  // side data delayed to match the root pipeline
  ctl_t                dl_ctl_r [W];
  logic signed [W-1:0] dl_px_r  [W];
  logic signed [W-1:0] dl_py_r  [W];
  logic signed [W-1:0] dl_rlx_r [W];
  logic signed [W-1:0] dl_rly_r [W];
  logic        [W-2:0] dl_rad_r [W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < W; i++) begin
        dl_ctl_r[i] <= '0;
      end
    end else begin
      dl_ctl_r[0] <= f_ctl;
      for (int i = 1; i < W; i++) begin
        dl_ctl_r[i] <= dl_ctl_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dl_px_r[0]  <= f_px;
    dl_py_r[0]  <= f_py;
    dl_rlx_r[0] <= f_rlx;
    dl_rly_r[0] <= f_rly;
    dl_rad_r[0] <= f_rad;
    for (int i = 1; i < W; i++) begin
      dl_px_r[i]  <= dl_px_r[i-1];
      dl_py_r[i]  <= dl_py_r[i-1];
      dl_rlx_r[i] <= dl_rlx_r[i-1];
      dl_rly_r[i] <= dl_rly_r[i-1];
      dl_rad_r[i] <= dl_rad_r[i-1];
    end
  end

  // back stages
  status_t b_status;

  ctbb_back #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_in    (dl_ctl_r[W-1]),
    .pos_x     (dl_px_r[W-1]),
    .pos_y     (dl_py_r[W-1]),
    .rlin_x    (dl_rlx_r[W-1]),
    .rlin_y    (dl_rly_r[W-1]),
    .rad       (dl_rad_r[W-1]),
    .root_x    (root_x),
    .root_y    (root_y),
    .out_valid (out_valid),
    .box_left  (out_box_left),
    .box_top   (out_box_top),
    .box_right (out_box_right),
    .box_bottom(out_box_bottom),
    .status    (b_status)
  );

  assign out_status = b_status;

endmodule

[rtl/ctbb_checker.sv]
// ----------------------------------------------------------------------------
// ctbb_checker
// port-level checks of the circle bounding box block, bound to the top level
// ----------------------------------------------------------------------------
`include "circle_transformed_bounding_box_assert.svh"

module ctbb_checker #(
  parameter int COORD_WIDTH = ctbb_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = ctbb_pkg::FRAC_BITS_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic signed [COORD_WIDTH-1:0]    in_center_x,
  input logic signed [COORD_WIDTH-1:0]    in_center_y,
  input logic        [COORD_WIDTH-2:0]    in_radius,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [ctbb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input logic [COORD_WIDTH-1:0]           cfg_data,
  input logic                             out_valid,
  input logic signed [COORD_WIDTH-1:0]    out_box_left,
  input logic signed [COORD_WIDTH-1:0]    out_box_top,
  input logic signed [COORD_WIDTH-1:0]    out_box_right,
  input logic signed [COORD_WIDTH-1:0]    out_box_bottom,
  input logic [ctbb_pkg::STATUS_W-1:0]    out_status
);
  import ctbb_pkg::*;

  // request to result latency in cycles
  localparam int LAT = COORD_WIDTH + 7;

  // every result comes from a request a fixed time earlier
  `CTBB_ASSERT_HOLDS(a_result_has_request, out_valid, $past(start && !busy, LAT),
                     "result without a matching request")

  // a failed transform gives an empty box
  `CTBB_ASSERT_HOLDS(a_fail_zero_box, out_valid && (out_status != STATUS_OK),
                     (out_box_left == '0) && (out_box_top == '0) &&
                     (out_box_right == '0) && (out_box_bottom == '0),
                     "non-zero box with failure status")

  // edges come out ordered
  `CTBB_ASSERT_HOLDS(a_edges_ordered, out_valid && (out_status == STATUS_OK),
                     (out_box_left <= out_box_right) && (out_box_top <= out_box_bottom),
                     "box edges out of order")

  // busy only lingers for the cycle after reset
  `CTBB_ASSERT_HOLDS(a_busy_clears, rst_n && $past(rst_n), !busy, "busy held after reset")

endmodule

bind circle_transformed_bounding_box ctbb_checker #(
  .COORD_WIDTH(COORD_WIDTH),
  .FRAC_BITS  (FRAC_BITS)
) u_ctbb_checker (.*);
